### hdl/line_sensor_centroid_macros.svh
// ----------------------------------------------------------------------------
// line_sensor_centroid_macros
// assertion helpers used by the line sensor centroid rtl
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_CENTROID_MACROS_SVH
`define LINE_SENSOR_CENTROID_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_sensor_centroid: assertion failed");

// next-cycle implication, checked out of reset
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_sensor_centroid: assertion failed");

`else

`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// widths, register codes and item types of the line sensor centroid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    localparam int NUM_SENSORS = 9;
    localparam int SAMPLE_BITS = 16;

    localparam int FIELD_W   = 16;
    localparam int CFG_W     = 16;
    localparam int POS_W     = 19;
    localparam int CFG_IDX_W = 2;

    // corrected reading, plain sum, index-weighted sum, scaled sum
    localparam int SB      = SAMPLE_BITS;
    localparam int SW      = SB + $clog2(NUM_SENSORS);
    localparam int KSUM    = NUM_SENSORS * (NUM_SENSORS - 1) / 2;
    localparam int TW      = SB + $clog2(KSUM + 1);
    localparam int WW      = CFG_W + TW;
    localparam int NGRP    = (NUM_SENSORS + 2) / 3;

    // stage map: correct, group sums, total sums, scale, then one per quotient bit
    localparam int ST_COR  = 0;
    localparam int ST_GRP  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_DIV  = 4;
    localparam int NSTG    = ST_DIV + POS_W;

    localparam logic [CFG_IDX_W-1:0] REG_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] MIN_RESET = '0;
    localparam logic [CFG_W-1:0] MAX_RESET = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] sensor_0;
        logic [FIELD_W-1:0] sensor_1;
        logic [FIELD_W-1:0] sensor_2;
        logic [FIELD_W-1:0] sensor_3;
        logic [FIELD_W-1:0] sensor_4;
        logic [FIELD_W-1:0] sensor_5;
        logic [FIELD_W-1:0] sensor_6;
        logic [FIELD_W-1:0] sensor_7;
        logic [FIELD_W-1:0] sensor_8;
    } t_lsc_in;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             line_seen;
    } t_lsc_out;

endpackage

`default_nettype wire

### hdl/line_sensor_centroid.sv
// ----------------------------------------------------------------------------
// line_sensor_centroid
// weighted centroid of one frame of line sensor readings, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   input channel  (i_in_valid / o_in_ready / i_in_data): one item is a frame
//     of nine raw readings. output channel (o_out_valid / i_out_ready /
//     o_out_data): one item per frame, position and line_seen.
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//     index 0 writes min_value, index 1 writes max_value, others are dropped.
//     o_cfg_ready is always high; write only while the pipeline is empty.
//   throughput: one item per clock unless the output stalls; 23 register stages
//     (correct, group sums, totals, scale multiply, 19 restoring divide stages)
//   reset: all stage valid bits clear, min_value = 0, max_value = 65535
//   stall: each stage holds while the one after it is full and stalled, so
//     bubbles close up and input is taken until all 23 stages are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_sensor_centroid_macros.svh"

module line_sensor_centroid
    import lsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_lsc_in              i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_lsc_out                  o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [CFG_W-1:0] r_min;
    logic [CFG_W-1:0] r_max;

    // per-stage valid bits and advance enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;

    // stage 0: corrected readings and weight step
    logic [SB-1:0]    n_v [NUM_SENSORS];
    logic [SB-1:0]    r_v [NUM_SENSORS];
    logic [CFG_W-1:0] n_step;
    logic [CFG_W-1:0] r_step0;
    logic [FIELD_W-1:0] w_raw [9];

    // stage 1: sums over groups of three sensors
    logic [SW-1:0]    n_gs [NGRP];
    logic [TW-1:0]    n_gt [NGRP];
    logic [SW-1:0]    r_gs [NGRP];
    logic [TW-1:0]    r_gt [NGRP];
    logic [CFG_W-1:0] r_step1;

    // stage 2: totals
    logic [SW-1:0]    n_s2;
    logic [TW-1:0]    n_t2;
    logic [SW-1:0]    r_s2;
    logic [TW-1:0]    r_t2;
    logic [CFG_W-1:0] r_step2;

    // stage 3: scaled weighted sum
    logic [WW-1:0]    r_w3;
    logic [SW-1:0]    r_s3;
    logic             r_seen3;

    // divide stages: partial remainder, unused dividend bits, quotient so far
    logic [SW-1:0]    n_rem [POS_W];
    logic [POS_W-1:0] n_low [POS_W];
    logic [POS_W-1:0] n_quo [POS_W];
    logic [SW-1:0]    r_rem [POS_W];
    logic [POS_W-1:0] r_low [POS_W];
    logic [POS_W-1:0] r_quo [POS_W];
    logic [SW-1:0]    r_den [POS_W];
    logic             r_seen [POS_W];

    // ready chain: a stage can take data when empty or when it drains itself
    always_comb begin
        w_adv[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (w_adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN: r_min <= i_cfg_data;
                REG_MAX: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: subtract dark level, clamp at zero
    always_comb begin
        w_raw[0] = i_in_data.sensor_0;
        w_raw[1] = i_in_data.sensor_1;
        w_raw[2] = i_in_data.sensor_2;
        w_raw[3] = i_in_data.sensor_3;
        w_raw[4] = i_in_data.sensor_4;
        w_raw[5] = i_in_data.sensor_5;
        w_raw[6] = i_in_data.sensor_6;
        w_raw[7] = i_in_data.sensor_7;
        w_raw[8] = i_in_data.sensor_8;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            if (CFG_W'(w_raw[k][SB-1:0]) > r_min) begin
                n_v[k] = SB'(CFG_W'(w_raw[k][SB-1:0]) - r_min);
            end else begin
                n_v[k] = '0;
            end
        end
        // max below min gives a zero weight step
        n_step = (r_max >= r_min) ? (r_max - r_min) : '0;
    end

    // stage 1: partial sums, weight k is a constant multiply
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_gs[g] = '0;
            n_gt[g] = '0;
            for (int j = 0; j < 3; j++) begin
                if (3 * g + j < NUM_SENSORS) begin
                    n_gs[g] = n_gs[g] + SW'(r_v[3*g+j]);
                    n_gt[g] = n_gt[g] + TW'(r_v[3*g+j]) * TW'(3 * g + j);
                end
            end
        end
    end

    // stage 2: totals
    always_comb begin
        n_s2 = '0;
        n_t2 = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_s2 = n_s2 + r_gs[g];
            n_t2 = n_t2 + r_gt[g];
        end
    end

    // divide stages: one restoring step each, quotient known below 2^POS_W
    always_comb begin
        logic [SW-1:0]    rem_in;
        logic [POS_W-1:0] low_in;
        logic [POS_W-1:0] quo_in;
        logic [SW-1:0]    den_in;
        logic [SW:0]      trial;
        for (int j = 0; j < POS_W; j++) begin
            if (j == 0) begin
                rem_in = SW'(r_w3 >> POS_W);
                low_in = r_w3[POS_W-1:0];
                quo_in = '0;
                den_in = r_s3;
            end else begin
                rem_in = r_rem[j-1];
                low_in = r_low[j-1];
                quo_in = r_quo[j-1];
                den_in = r_den[j-1];
            end
            trial = {rem_in, low_in[POS_W-1]};
            if (trial >= {1'b0, den_in}) begin
                n_rem[j] = SW'(trial - {1'b0, den_in});
                n_quo[j] = {quo_in[POS_W-2:0], 1'b1};
            end else begin
                n_rem[j] = SW'(trial);
                n_quo[j] = {quo_in[POS_W-2:0], 1'b0};
            end
            n_low[j] = {low_in[POS_W-2:0], 1'b0};
        end
    end

    // payload registers, each loads when its stage advances
    always_ff @(posedge i_clk) begin
        if (w_adv[ST_COR]) begin
            for (int k = 0; k < NUM_SENSORS; k++) begin
                r_v[k] <= n_v[k];
            end
            r_step0 <= n_step;
        end
        if (w_adv[ST_GRP]) begin
            for (int g = 0; g < NGRP; g++) begin
                r_gs[g] <= n_gs[g];
                r_gt[g] <= n_gt[g];
            end
            r_step1 <= r_step0;
        end
        if (w_adv[ST_SUM]) begin
            r_s2    <= n_s2;
            r_t2    <= n_t2;
            r_step2 <= r_step1;
        end
        if (w_adv[ST_MUL]) begin
            r_w3    <= WW'(r_step2) * WW'(r_t2);
            r_s3    <= r_s2;
            r_seen3 <= (r_s2 != '0);
        end
        for (int j = 0; j < POS_W; j++) begin
            if (w_adv[ST_DIV+j]) begin
                r_rem[j]  <= n_rem[j];
                r_low[j]  <= n_low[j];
                r_den[j]  <= (j == 0) ? r_s3 : r_den[j-1];
                r_seen[j] <= (j == 0) ? r_seen3 : r_seen[j-1];
                // a zero sum divides to all ones, so the last stage forces zero
                if (j == POS_W - 1) begin
                    r_quo[j] <= ((j == 0) ? r_seen3 : r_seen[j-1]) ? n_quo[j] : '0;
                end else begin
                    r_quo[j] <= n_quo[j];
                end
            end
        end
    end

    assign o_out_valid          = r_vld[NSTG-1];
    assign o_out_data.position  = r_quo[POS_W-1];
    assign o_out_data.line_seen = r_seen[POS_W-1];

    // no line means a zero position
    `LSC_ASSERT_IMPL(a_no_line_zero, i_clk, i_rst_n,
        o_out_valid && !o_out_data.line_seen, o_out_data.position == '0)
    // input is refused only when every stage holds an item
    `LSC_ASSERT_IMPL(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, &r_vld)
    // final remainder stays below the divisor
    `LSC_ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n,
        o_out_valid && o_out_data.line_seen, r_rem[POS_W-1] < r_den[POS_W-1])

endmodule

`default_nettype wire
